// File: src/ctds_pkg.sv
`timescale 1ns / 1ps

package ctds_pkg;

  localparam int unsigned FRAMES_W  = 16;
  localparam int unsigned DIV_W     = 8;
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned TIMER_W   = 24;
  localparam int unsigned DROPS_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAMES_TOTAL   = 3'd0,
    CFG_TOP_DIVISOR    = 3'd1,
    CFG_PULSE_WIDTH_US = 3'd2,
    CFG_DELAY_US       = 3'd3,
    CFG_HOLDOFF_US     = 3'd4,
    CFG_MANUAL_WAIT_US = 3'd5
  } cfg_reg_t;

  localparam logic [FRAMES_W-1:0] RST_FRAMES_TOTAL   = 16'd100;
  localparam logic [DIV_W-1:0]    RST_TOP_DIVISOR    = 8'd1;
  localparam logic [PULSE_W-1:0]  RST_PULSE_WIDTH_US = 16'd900;
  localparam logic [TIMER_W-1:0]  RST_DELAY_US       = 24'd0;
  localparam logic [TIMER_W-1:0]  RST_HOLDOFF_US     = 24'd2000000;
  localparam logic [TIMER_W-1:0]  RST_MANUAL_WAIT_US = 24'd125000;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DELAY     = 3'd1,
    PH_PULSE     = 3'd2,
    PH_FRAMES    = 3'd3,
    PH_HOLDOFF   = 3'd4,
    PH_MAN_PRE   = 3'd5,
    PH_MAN_PULSE = 3'd6,
    PH_MAN_POST  = 3'd7
  } phase_t;

endpackage

// File: src/ctds_if.sv
`timescale 1ns / 1ps

interface ctds_in_if;
  logic valid;
  logic ready;
  logic arm;
  logic sync_edge;
  logic frame_tick;
  logic manual_drop;

  modport source (output valid, arm, sync_edge, frame_tick, manual_drop, input ready);
  modport sink (input valid, arm, sync_edge, frame_tick, manual_drop, output ready);
endinterface

interface ctds_out_if;
  import ctds_pkg::*;
  logic               valid;
  logic               ready;
  logic               side_strobe;
  logic               top_strobe;
  logic               piezo_positive;
  logic               busy_res;
  logic [DROPS_W-1:0] drops_made;
  logic               sequence_done;

  modport source (output valid, side_strobe, top_strobe, piezo_positive, busy_res,
                  drops_made, sequence_done, input ready);
  modport sink (input valid, side_strobe, top_strobe, piezo_positive, busy_res,
                drops_made, sequence_done, output ready);
endinterface

// File: src/camera_trigger_droplet_sequencer_top.sv
`timescale 1ns / 1ps

// Droplet camera trigger sequencer. Each input transaction is one microsecond
// tick and yields exactly one result transaction. An item is taken every
// cycle: the tick is evaluated in one pass of logic against the sequence
// state and the result lands in the output register, so the only stall is a
// full output register that the sink has not yet taken. Configuration
// registers are written through cfg_we/cfg_index/cfg_data; unknown indexes
// are ignored.
module camera_trigger_droplet_sequencer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  ctds_in_if.sink                          in_chan,
  ctds_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [ctds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctds_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ctds_pkg::*;

  logic [FRAMES_W-1:0] frames_total_r;
  logic [DIV_W-1:0]    top_divisor_r;
  logic [PULSE_W-1:0]  pulse_width_r;
  logic [TIMER_W-1:0]  delay_r;
  logic [TIMER_W-1:0]  holdoff_r;
  logic [TIMER_W-1:0]  manual_wait_r;

  phase_t              phase_r, phase_nxt;
  logic                armed_r, armed_nxt;
  logic                strobing_r, strobing_nxt;
  logic [FRAMES_W-1:0] frame_count_r, frame_count_nxt;
  logic [DIV_W-1:0]    top_phase_r, top_phase_nxt;
  logic [TIMER_W-1:0]  wait_timer_r, wait_timer_nxt;
  logic [DROPS_W-1:0]  drop_total_r, drop_total_nxt;

  logic                side_nxt, top_nxt, piezo_nxt, done_nxt;
  logic                out_valid_r;
  logic                side_r, top_r, piezo_r, busy_r, done_r;
  logic                accept;
  logic [DIV_W-1:0]    div_eff;
  logic [DIV_W:0]      top_sum;
  logic [FRAMES_W:0]   count_plus;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_total_r <= RST_FRAMES_TOTAL;
      top_divisor_r  <= RST_TOP_DIVISOR;
      pulse_width_r  <= RST_PULSE_WIDTH_US;
      delay_r        <= RST_DELAY_US;
      holdoff_r      <= RST_HOLDOFF_US;
      manual_wait_r  <= RST_MANUAL_WAIT_US;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAMES_TOTAL:   frames_total_r <= cfg_data[FRAMES_W-1:0];
        CFG_TOP_DIVISOR:    top_divisor_r  <= cfg_data[DIV_W-1:0];
        CFG_PULSE_WIDTH_US: pulse_width_r  <= cfg_data[PULSE_W-1:0];
        CFG_DELAY_US:       delay_r        <= cfg_data[TIMER_W-1:0];
        CFG_HOLDOFF_US:     holdoff_r      <= cfg_data[TIMER_W-1:0];
        CFG_MANUAL_WAIT_US: manual_wait_r  <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_eff = (top_divisor_r == '0) ? DIV_W'(1) : top_divisor_r;

  always_comb begin
    armed_nxt       = armed_r || in_chan.arm;
    strobing_nxt    = strobing_r;
    frame_count_nxt = frame_count_r;
    top_phase_nxt   = top_phase_r;
    wait_timer_nxt  = wait_timer_r;
    drop_total_nxt  = drop_total_r;
    phase_nxt       = phase_r;
    side_nxt        = 1'b0;
    top_nxt         = 1'b0;
    piezo_nxt       = 1'b0;
    done_nxt        = 1'b0;
    top_sum         = {1'b0, top_phase_r} + (DIV_W+1)'(1);

    // frame strobes use the strobing flag from the start of the tick
    if (strobing_r && in_chan.frame_tick) begin
      side_nxt        = 1'b1;
      top_nxt         = (frame_count_r == '0) || (top_phase_r == '0);
      frame_count_nxt = frame_count_r + FRAMES_W'(1);
      top_phase_nxt   = (top_sum >= {1'b0, div_eff}) ? '0 : top_sum[DIV_W-1:0];
    end

    count_plus = {1'b0, frame_count_nxt} + (FRAMES_W+1)'(1);

    case (phase_r)
      PH_IDLE: begin
        if (in_chan.sync_edge && armed_nxt) begin
          strobing_nxt   = 1'b1;
          phase_nxt      = PH_DELAY;
          wait_timer_nxt = delay_r;
        end else if (in_chan.manual_drop) begin
          phase_nxt      = PH_MAN_PRE;
          wait_timer_nxt = manual_wait_r;
        end
      end
      PH_DELAY: begin
        if (wait_timer_r == '0) begin
          phase_nxt      = PH_PULSE;
          wait_timer_nxt = TIMER_W'(pulse_width_r);
        end else begin
          wait_timer_nxt = wait_timer_r - TIMER_W'(1);
        end
      end
      PH_PULSE: begin
        if (wait_timer_r == '0) begin
          phase_nxt = PH_FRAMES;
        end else begin
          piezo_nxt      = 1'b1;
          wait_timer_nxt = wait_timer_r - TIMER_W'(1);
        end
      end
      PH_FRAMES: begin
        if (count_plus >= {1'b0, frames_total_r}) begin
          strobing_nxt    = 1'b0;
          armed_nxt       = 1'b0;
          frame_count_nxt = '0;
          top_phase_nxt   = '0;
          drop_total_nxt  = drop_total_r + DROPS_W'(1);
          done_nxt        = 1'b1;
          phase_nxt       = PH_HOLDOFF;
          wait_timer_nxt  = holdoff_r;
        end
      end
      PH_MAN_PRE: begin
        if (wait_timer_r == '0) begin
          phase_nxt      = PH_MAN_PULSE;
          wait_timer_nxt = TIMER_W'(pulse_width_r);
        end else begin
          wait_timer_nxt = wait_timer_r - TIMER_W'(1);
        end
      end
      PH_MAN_PULSE: begin
        if (wait_timer_r == '0) begin
          drop_total_nxt = drop_total_r + DROPS_W'(1);
          phase_nxt      = PH_MAN_POST;
          wait_timer_nxt = manual_wait_r;
        end else begin
          piezo_nxt      = 1'b1;
          wait_timer_nxt = wait_timer_r - TIMER_W'(1);
        end
      end
      default: begin
        // holdoff and post-drop wait both return to idle
        if (wait_timer_r == '0) begin
          phase_nxt = PH_IDLE;
        end else begin
          wait_timer_nxt = wait_timer_r - TIMER_W'(1);
        end
      end
    endcase
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      armed_r       <= 1'b0;
      strobing_r    <= 1'b0;
      frame_count_r <= '0;
      top_phase_r   <= '0;
      wait_timer_r  <= '0;
      drop_total_r  <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      armed_r       <= armed_nxt;
      strobing_r    <= strobing_nxt;
      frame_count_r <= frame_count_nxt;
      top_phase_r   <= top_phase_nxt;
      wait_timer_r  <= wait_timer_nxt;
      drop_total_r  <= drop_total_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      side_r  <= side_nxt;
      top_r   <= top_nxt;
      piezo_r <= piezo_nxt;
      busy_r  <= (phase_nxt != PH_IDLE);
      done_r  <= done_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.side_strobe    = side_r;
  assign out_chan.top_strobe     = top_r;
  assign out_chan.piezo_positive = piezo_r;
  assign out_chan.busy_res       = busy_r;
  assign out_chan.drops_made     = drop_total_r;
  assign out_chan.sequence_done  = done_r;

endmodule
